// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/arvt_pkg.sv =====
// Shared constants, command codes and the status struct of the timer bank.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package arvt_pkg;

  localparam int TIMER_COUNT_DEF = 16;
  localparam int CNT_W = 36;
  localparam int IDX_W = 5;
  localparam int DIV_W = 45;

  // Division by 1000: drop three bits, then multiply by ceil(2^49 / 125).
  localparam int Y_W = DIV_W - 3;
  localparam int CHUNK_W = 14;
  localparam int RECIP_W = 43;
  localparam int PP_W = CHUNK_W + RECIP_W;
  localparam int ACC_W = Y_W + RECIP_W;
  localparam int RECIP_SHIFT = 49;
  localparam int DIV_STEPS = Y_W / CHUNK_W;
  localparam logic [RECIP_W-1:0] RECIP_125 = 43'd4503599627371;

  localparam logic [CNT_W-1:0] CNT_MASK = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] NO_TIMER = CNT_W'(99999999);
  localparam logic [3:0] RATE_MAX = 4'd12;
  localparam logic [43:0] MIN_SCALED = 44'd9500;
  localparam logic [CNT_W-1:0] THRESHOLD_TICKS = CNT_W'(20);
  localparam logic [DIV_W-1:0] ROUND_HALF = DIV_W'(500);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_STATE = 3'd1;
  localparam logic [2:0] ST_INDEX = 3'd2;
  localparam logic [2:0] ST_KIND = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;

  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_LOAD = 4'd1;
  localparam logic [3:0] CMD_DEC = 4'd2;
  localparam logic [3:0] CMD_DIV = 4'd3;
  localparam logic [3:0] CMD_RESC = 4'd4;
  localparam logic [3:0] CMD_SWR = 4'd5;
  localparam logic [3:0] CMD_MIN = 4'd6;
  localparam logic [3:0] CMD_MEND = 4'd7;
  localparam logic [3:0] CMD_HALVE = 4'd8;
  localparam logic [3:0] CMD_HEND = 4'd9;
  localparam logic [3:0] CMD_HDONE = 4'd10;
  localparam logic [3:0] CMD_TICK = 4'd11;
  localparam logic [3:0] CMD_TEMIT = 4'd12;
  localparam logic [3:0] CMD_TEND = 4'd13;
  localparam logic [3:0] CMD_FIN = 4'd14;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] err;
    logic       is_short;
    logic       chg;
    logic       div_last;
    logic       walk_last;
    logic       found;
    logic       hm_gt;
    logic       hend_chg;
    logic       tk_expire;
    logic       tk_halt;
    logic       cur_last;
    logic       emit_ok;
    logic       out_free;
    logic [3:0] rate;
  } arvt_stat_t;

  function automatic logic [CNT_W-1:0] shl_sat(input logic [CNT_W-1:0] v,
                                               input logic [3:0] k);
    logic [CNT_W-1:0] lim;
    lim = CNT_MASK >> k;
    if (v > lim) return CNT_MASK;
    return v << k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/arvt_datapath.sv =====
// Datapath of the timer bank: timer entries, divider, rescaler and result registers.
// Driven by arvt_ctrl through command codes; uses arvt_pkg.
`default_nettype none

module arvt_datapath #(
  parameter int TIMER_COUNT = arvt_pkg::TIMER_COUNT_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [3:0]              cmd,
  output arvt_pkg::arvt_stat_t         stat,
  input  wire logic [1:0]              mode,
  input  wire logic [4:0]              timer_index,
  input  wire logic [1:0]              timer_kind,
  input  wire logic [31:0]             interval_ms,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   status,
  output logic                         fired,
  output logic [4:0]                   fired_index,
  output logic [3:0]                   tick_rate,
  output logic                         rate_changed,
  output logic                         last
);

  localparam int PW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CW = arvt_pkg::CNT_W;
  localparam logic [PW-1:0] LAST_P = PW'(TIMER_COUNT - 1);

  logic [1:0]  mode_r;
  logic [4:0]  idx_r;
  logic [1:0]  kind_r;
  logic [31:0] ms_r;

  logic [TIMER_COUNT-1:0] run_q;
  logic [TIMER_COUNT-1:0] rep_q;
  logic [CW-1:0] rem_q [TIMER_COUNT];
  logic [CW-1:0] rld_q [TIMER_COUNT];
  logic [3:0]    rate_q;
  logic [4:0]    sidx_q;
  logic [CW-1:0] scnt_q;

  logic [PW-1:0] ptr;
  logic [PW-1:0] cur;
  logic [arvt_pkg::Y_W-1:0]   ysh;
  logic [arvt_pkg::ACC_W-1:0] acc;
  logic [5:0]    dcnt;
  logic          rs_left;
  logic [3:0]    rs_k;
  logic [3:0]    rs_tgt;
  logic          chg_r;
  logic [2:0]    err_r;
  logic          found_r;
  logic [CW-1:0] mmin;
  logic [PW-1:0] best;
  logic [CW-1:0] hm;
  logic [5:0]    diff;
  logic          pend_v;
  logic [4:0]    pend_idx;
  logic          pend_chg;
  logic [3:0]    pend_rate;

  logic          idx_ok;
  logic [PW-1:0] idx_p;
  logic [2:0]    err_c;
  logic          low;
  logic [3:0]    nr;
  logic [3:0]    fr;
  logic [arvt_pkg::DIV_W-1:0] dv_init;
  logic [arvt_pkg::PP_W-1:0]  pp;
  logic [PW-1:0] ra;
  logic [CW-1:0] rd_rem;
  logic [CW-1:0] rd_rld;
  logic [CW-1:0] dec;
  logic [CW-1:0] q;
  logic          cand;
  logic [3:0]    nrate;
  logic          out_free;
  logic          emit_ok;
  logic          push;
  logic [2:0]    push_status;
  logic          push_fired;
  logic [4:0]    push_idx;
  logic [3:0]    push_rate;
  logic          push_chg;
  logic          push_last;

  function automatic logic [CW-1:0] resc(input logic [CW-1:0] v, input logic left,
                                         input logic [3:0] k);
    if (left) return arvt_pkg::shl_sat(v, k);
    return v >> k;
  endfunction

  assign idx_ok = {1'b0, idx_r} < 6'(TIMER_COUNT);
  assign idx_p  = idx_r[PW-1:0];

  always_comb begin
    err_c = arvt_pkg::ST_OK;
    if (mode_r == arvt_pkg::MODE_START) begin
      priority if (!idx_ok) err_c = arvt_pkg::ST_INDEX;
      else if (kind_r > 2'd1) err_c = arvt_pkg::ST_KIND;
      else if (run_q[idx_p]) err_c = arvt_pkg::ST_STATE;
      else if (ms_r == 32'd0) err_c = arvt_pkg::ST_SHORT;
      else err_c = arvt_pkg::ST_OK;
    end else if (mode_r == arvt_pkg::MODE_STOP) begin
      priority if (!idx_ok) err_c = arvt_pkg::ST_INDEX;
      else if (!run_q[idx_p]) err_c = arvt_pkg::ST_STATE;
      else err_c = arvt_pkg::ST_OK;
    end
  end

  // Rate search: the count reaches ten ticks once ms << n is at least 9500.
  always_comb begin
    low = ((44'(ms_r) << rate_q) < arvt_pkg::MIN_SCALED) && (rate_q < arvt_pkg::RATE_MAX);
    nr = arvt_pkg::RATE_MAX;
    for (int n = 12; n >= 0; n--) begin
      if ((4'(n) > rate_q) && ((44'(ms_r) << n) >= arvt_pkg::MIN_SCALED)) nr = 4'(n);
    end
    fr = low ? nr : rate_q;
    dv_init = (arvt_pkg::DIV_W'(ms_r) << fr) + arvt_pkg::ROUND_HALF;
  end

  // Reciprocal multiply, top chunk first, one 14-bit chunk per cycle.
  assign pp = arvt_pkg::PP_W'(ysh[arvt_pkg::Y_W-1 -: arvt_pkg::CHUNK_W]) *
              arvt_pkg::PP_W'(arvt_pkg::RECIP_125);
  assign q  = acc[arvt_pkg::RECIP_SHIFT +: CW];

  assign ra     = (cmd == arvt_pkg::CMD_TICK) ? cur : ptr;
  assign rd_rem = rem_q[ra];
  assign rd_rld = rld_q[ra];
  assign dec    = rd_rem - CW'(1);
  assign cand   = run_q[ptr] && (!found_r || (rd_rem < mmin));

  always_comb begin
    nrate = 4'd0;
    if (found_r && (diff < {2'b00, rate_q})) nrate = 4'(rate_q - diff[3:0]);
  end

  assign out_free = !out_valid || out_ready;
  assign emit_ok  = !pend_v || out_free;

  always_comb begin
    stat.mode      = mode_r;
    stat.err       = err_c;
    stat.is_short  = idx_r == sidx_q;
    stat.chg       = chg_r;
    stat.div_last  = dcnt == 6'(arvt_pkg::DIV_STEPS - 1);
    stat.walk_last = ptr == LAST_P;
    stat.found     = found_r;
    stat.hm_gt     = hm > arvt_pkg::THRESHOLD_TICKS;
    stat.hend_chg  = nrate != rate_q;
    stat.tk_expire = run_q[cur] && (dec == '0);
    stat.tk_halt   = run_q[cur] && (dec == '0) && !rep_q[cur] && (5'(cur) == sidx_q);
    stat.cur_last  = cur == LAST_P;
    stat.emit_ok   = emit_ok;
    stat.out_free  = out_free;
    stat.rate      = rate_q;
  end

  always_ff @(posedge clk) begin
    if (cmd == arvt_pkg::CMD_LOAD) begin
      mode_r <= mode;
      idx_r  <= timer_index;
      kind_r <= timer_kind;
      ms_r   <= interval_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_q  <= '0;
      rate_q <= 4'd0;
      sidx_q <= 5'd0;
      scnt_q <= arvt_pkg::NO_TIMER;
      ptr    <= '0;
      cur    <= '0;
      pend_v <= 1'b0;
      dcnt   <= 6'd0;
    end else begin
      unique case (cmd)
        arvt_pkg::CMD_DEC: begin
          err_r   <= err_c;
          chg_r   <= (mode_r == arvt_pkg::MODE_START && err_c == arvt_pkg::ST_OK) ?
                     low : 1'b0;
          found_r <= 1'b0;
          ptr     <= '0;
          cur     <= '0;
          pend_v  <= 1'b0;
          ysh     <= dv_init[arvt_pkg::DIV_W-1 -: arvt_pkg::Y_W];
          acc     <= '0;
          dcnt    <= 6'd0;
          rs_left <= 1'b1;
          rs_k    <= 4'(nr - rate_q);
          rs_tgt  <= nr;
          if (mode_r == arvt_pkg::MODE_STOP && err_c == arvt_pkg::ST_OK)
            run_q[idx_p] <= 1'b0;
        end
        arvt_pkg::CMD_DIV: begin
          acc  <= (acc << arvt_pkg::CHUNK_W) + arvt_pkg::ACC_W'(pp);
          ysh  <= ysh << arvt_pkg::CHUNK_W;
          dcnt <= 6'(dcnt + 6'd1);
        end
        arvt_pkg::CMD_RESC: begin
          rem_q[ptr] <= resc(rd_rem, rs_left, rs_k);
          rld_q[ptr] <= resc(rd_rld, rs_left, rs_k);
          if (ptr == LAST_P) begin
            scnt_q <= resc(scnt_q, rs_left, rs_k);
            rate_q <= rs_tgt;
            ptr    <= '0;
          end else begin
            ptr <= PW'(ptr + 1'b1);
          end
        end
        arvt_pkg::CMD_SWR: begin
          rem_q[idx_p] <= q;
          rld_q[idx_p] <= q;
          rep_q[idx_p] <= kind_r == 2'd0;
          run_q[idx_p] <= 1'b1;
          if (q < scnt_q) begin
            scnt_q <= q;
            sidx_q <= idx_r;
          end
        end
        arvt_pkg::CMD_MIN: begin
          if (cand) begin
            mmin    <= rd_rem;
            best    <= ptr;
            found_r <= 1'b1;
          end
          ptr <= (ptr == LAST_P) ? '0 : PW'(ptr + 1'b1);
        end
        arvt_pkg::CMD_MEND: begin
          if (found_r) begin
            scnt_q <= mmin;
            sidx_q <= 5'(best);
            hm     <= mmin;
            diff   <= 6'd0;
          end
        end
        arvt_pkg::CMD_HALVE: begin
          if (hm > arvt_pkg::THRESHOLD_TICKS) begin
            hm   <= hm >> 1;
            diff <= 6'(diff + 6'd1);
          end
        end
        arvt_pkg::CMD_HEND: begin
          rs_left <= 1'b0;
          rs_k    <= 4'(rate_q - nrate);
          rs_tgt  <= nrate;
          chg_r   <= nrate != rate_q;
        end
        arvt_pkg::CMD_HDONE: begin
          if (!found_r) scnt_q <= arvt_pkg::NO_TIMER;
        end
        arvt_pkg::CMD_TICK: begin
          chg_r   <= 1'b0;
          found_r <= 1'b0;
          if (run_q[cur]) begin
            if (dec == '0) begin
              if (rep_q[cur]) begin
                rem_q[cur] <= rld_q[cur];
              end else begin
                rem_q[cur] <= '0;
                run_q[cur] <= 1'b0;
              end
            end else begin
              rem_q[cur] <= dec;
            end
          end
          if (!stat.tk_expire && cur != LAST_P) cur <= PW'(cur + 1'b1);
        end
        arvt_pkg::CMD_TEMIT: begin
          if (emit_ok) begin
            pend_v    <= 1'b1;
            pend_idx  <= 5'(cur);
            pend_chg  <= chg_r;
            pend_rate <= rate_q;
            if (cur != LAST_P) cur <= PW'(cur + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: loads from the pending tick result or the final word.
  always_comb begin
    push        = 1'b0;
    push_status = arvt_pkg::ST_OK;
    push_fired  = 1'b0;
    push_idx    = 5'd0;
    push_rate   = rate_q;
    push_chg    = 1'b0;
    push_last   = 1'b1;
    unique case (cmd)
      arvt_pkg::CMD_TEMIT: begin
        push       = emit_ok && pend_v;
        push_fired = 1'b1;
        push_idx   = pend_idx;
        push_rate  = pend_rate;
        push_chg   = pend_chg;
        push_last  = 1'b0;
      end
      arvt_pkg::CMD_TEND: begin
        push = out_free;
        if (pend_v) begin
          push_fired = 1'b1;
          push_idx   = pend_idx;
          push_rate  = pend_rate;
          push_chg   = pend_chg;
        end
      end
      arvt_pkg::CMD_FIN: begin
        push        = out_free;
        push_status = err_r;
        push_chg    = chg_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status       <= push_status;
      fired        <= push_fired;
      fired_index  <= push_idx;
      tick_rate    <= push_rate;
      rate_changed <= push_chg;
      last         <= push_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arvt_ctrl.sv =====
// Controller state machine of the timer bank: sequences the datapath commands.
// Reads the datapath status struct; uses arvt_pkg.
`default_nettype none

module arvt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  arvt_pkg::arvt_stat_t      stat,
  output logic [3:0]                cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RESC  = 4'd3;
  localparam logic [3:0] S_SWR   = 4'd4;
  localparam logic [3:0] S_MIN   = 4'd5;
  localparam logic [3:0] S_MEND  = 4'd6;
  localparam logic [3:0] S_HALVE = 4'd7;
  localparam logic [3:0] S_HEND  = 4'd8;
  localparam logic [3:0] S_HDONE = 4'd9;
  localparam logic [3:0] S_TICK  = 4'd10;
  localparam logic [3:0] S_TEMIT = 4'd11;
  localparam logic [3:0] S_TEND  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd = arvt_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = arvt_pkg::CMD_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd = arvt_pkg::CMD_DEC;
        priority if (stat.mode == arvt_pkg::MODE_TICK) state_next = S_TICK;
        else if (stat.err != arvt_pkg::ST_OK) state_next = S_FIN;
        else if (stat.mode == arvt_pkg::MODE_START) state_next = S_DIV;
        else if (stat.mode == arvt_pkg::MODE_STOP && stat.is_short) state_next = S_MIN;
        else state_next = S_FIN;
      end
      S_DIV: begin
        cmd = arvt_pkg::CMD_DIV;
        if (stat.div_last) state_next = stat.chg ? S_RESC : S_SWR;
      end
      S_RESC: begin
        cmd = arvt_pkg::CMD_RESC;
        if (stat.walk_last)
          state_next = (stat.mode == arvt_pkg::MODE_START) ? S_SWR : S_HDONE;
      end
      S_SWR: begin
        cmd = arvt_pkg::CMD_SWR;
        state_next = S_FIN;
      end
      S_MIN: begin
        cmd = arvt_pkg::CMD_MIN;
        if (stat.walk_last) state_next = S_MEND;
      end
      S_MEND: begin
        cmd = arvt_pkg::CMD_MEND;
        state_next = stat.found ? S_HALVE : S_HEND;
      end
      S_HALVE: begin
        cmd = arvt_pkg::CMD_HALVE;
        if (!stat.hm_gt) state_next = S_HEND;
      end
      S_HEND: begin
        cmd = arvt_pkg::CMD_HEND;
        state_next = stat.hend_chg ? S_RESC : S_HDONE;
      end
      S_HDONE: begin
        cmd = arvt_pkg::CMD_HDONE;
        state_next = (stat.mode == arvt_pkg::MODE_TICK) ? S_TEMIT : S_FIN;
      end
      S_TICK: begin
        cmd = arvt_pkg::CMD_TICK;
        priority if (stat.tk_halt) state_next = S_MIN;
        else if (stat.tk_expire) state_next = S_TEMIT;
        else if (stat.cur_last) state_next = S_TEND;
        else state_next = S_TICK;
      end
      S_TEMIT: begin
        cmd = arvt_pkg::CMD_TEMIT;
        if (stat.emit_ok) state_next = stat.cur_last ? S_TEND : S_TICK;
      end
      S_TEND: begin
        cmd = arvt_pkg::CMD_TEND;
        if (stat.out_free) state_next = S_IDLE;
      end
      S_FIN: begin
        cmd = arvt_pkg::CMD_FIN;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/adaptive_rate_virtual_timer_bank.sv =====
// Bank of virtual timers on one shared hardware tick whose rate is 2^tick_rate per second.
// The count is (ms << rate) + 500 divided by 1000, which drops three bits and multiplies
// by a reciprocal of 125, one 14-bit chunk a cycle. When the rate goes up, a walk over
// all entries rescales them. A stop of a timer that is not the shortest needs no walk;
// a stop of the shortest walks all entries to find the new minimum, halves it once a
// cycle until it is 20 or less, passes through the bookkeeping states, and walks all
// entries again to rescale when the rate drops. A tick walks the entries one per cycle,
// pausing for each expiry and taking the stop path above for each one-shot expiry of
// the shortest timer. All entries sit behind one read port that the walk steps through;
// a result word the receiver holds off stalls the block for as long as it waits.
// Results leave through an output register, so a new word is accepted while the last
// result still waits.
// Depends on arvt_pkg, arvt_ctrl, arvt_datapath and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module adaptive_rate_virtual_timer_bank #(
  parameter int TIMER_COUNT = arvt_pkg::TIMER_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [4:0]  timer_index,
  input  wire logic [1:0]  timer_kind,
  input  wire logic [31:0] interval_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic             fired,
  output logic [4:0]       fired_index,
  output logic [3:0]       tick_rate,
  output logic             rate_changed,
  output logic             last
);

  // Controller and datapath talk only through the command code and status struct.
  logic [3:0] cmd;
  arvt_pkg::arvt_stat_t stat;

  arvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  arvt_datapath #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .timer_index  (timer_index),
    .timer_kind   (timer_kind),
    .interval_ms  (interval_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .fired        (fired),
    .fired_index  (fired_index),
    .tick_rate    (tick_rate),
    .rate_changed (rate_changed),
    .last         (last)
  );

  // The stored rate never leaves the range the hardware clock supports.
  `ASSERT_NEVER(a_rate_range, stat.rate > arvt_pkg::RATE_MAX, "rate exponent above maximum")
  // An expiry report always carries an ok status.
  `ASSERT_IMPLIES(a_fired_ok, out_valid && fired, status == arvt_pkg::ST_OK, "fired with error")
  // Once a word is taken the block is busy until its work is done.
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule

`default_nettype wire
